// ===== sv/alacpk_pkg.sv =====
// ----------------------------------------------------------------------------
// alacpk_pkg
// Shared types and constants for the uncompressed frame packer.
// ----------------------------------------------------------------------------
package alacpk_pkg;

  localparam int unsigned MAX_FRAME_FRAMES = 4096;
  localparam int unsigned NOMINAL_RESET    = 4096;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAMES_W = 13;
  localparam int unsigned BUF_W    = 72;

  localparam logic [2:0] CHAN_CODE = 3'd1;

  typedef struct packed {
    logic [BUF_W-1:0] bits;        // left aligned, MSB first
    logic [3:0]       nbytes;      // bytes to emit, 2..9
    logic [6:0]       carry_bits;
    logic [2:0]       carry_count;
  } pack_t;

endpackage

// ===== sv/alacpk_compose.sv =====
// ----------------------------------------------------------------------------
// alacpk_compose
// Builds the bit image for one sample: pending bits, optional header and
// size field, then the sample; returns byte count and the new carry.
// ----------------------------------------------------------------------------
module alacpk_compose (
  input  logic [alacpk_pkg::SAMPLE_W-1:0] sample,
  input  logic                            first,
  input  logic                            last,
  input  logic [alacpk_pkg::FRAMES_W-1:0] frame_frames,
  input  logic [alacpk_pkg::FRAMES_W-1:0] nominal,
  input  logic [6:0]                      carry_bits,
  input  logic [2:0]                      carry_count,
  output alacpk_pkg::pack_t               result
);
  import alacpk_pkg::*;

  logic [31:0]      size32;
  logic             has_size;
  logic [2:0]       cc_eff;
  logic [6:0]       cb_eff;
  logic [BUF_W-1:0] payload;
  logic [6:0]       len;
  logic [6:0]       total;
  logic [BUF_W-1:0] prefix;
  logic [BUF_W-1:0] image;
  logic [BUF_W-1:0] shifted;
  logic [3:0]       nb;
  logic [2:0]       rem;
  logic [7:0]       tail;

  always_comb begin
    size32   = (32'(frame_frames) > 32'(MAX_FRAME_FRAMES)) ? 32'(MAX_FRAME_FRAMES)
                                                           : 32'(frame_frames);
    has_size = size32 != 32'(nominal);
    cc_eff   = first ? 3'd0 : carry_count;
    cb_eff   = first ? 7'd0 : carry_bits;

    if (first && has_size) begin
      payload = {CHAN_CODE, 16'h0000, 1'b1, 2'b00, 1'b1, size32, sample, 1'b0};
      len     = 7'd71;
    end else if (first) begin
      payload = {CHAN_CODE, 16'h0000, 1'b0, 2'b00, 1'b1, sample, 33'd0};
      len     = 7'd39;
    end else begin
      payload = {sample, 56'd0};
      len     = 7'd16;
    end

    total  = 7'(cc_eff) + len;
    prefix = {cb_eff, 65'd0} << (3'd7 - cc_eff);
    image  = prefix | (payload >> cc_eff);
    nb     = total[6:3];
    rem    = total[2:0];

    shifted = image << {nb, 3'b000};
    tail    = shifted[BUF_W-1 -: 8] >> (4'd8 - {1'b0, rem});

    result.bits        = image;
    result.nbytes      = nb + {3'd0, (last && (rem != 3'd0))};
    result.carry_bits  = last ? 7'd0 : tail[6:0];
    result.carry_count = last ? 3'd0 : rem;
  end

endmodule

// ===== sv/alac_uncompressed_frame_packer.sv =====
// ----------------------------------------------------------------------------
// alac_uncompressed_frame_packer
// Packs 16-bit stereo PCM samples into an uncompressed ALAC frame bitstream.
// ----------------------------------------------------------------------------
// Input stream: one channel sample per request. s_tuser marks the first
// sample of a frame (header, and size field when frame_frames differs from
// the nominal length, go out ahead of it); s_tlast marks the last sample and
// flushes the partial byte, zero filled.
// Output stream: one bitstream byte per request, MSB first; m_tlast is set on
// the final byte of a frame.
// cfg_we/cfg_wdata write the nominal frame length; write only while idle.
// Pipeline: an input register feeds a byte buffer of up to 9 bytes. The first
// byte of a sample reaches m_tdata once it has passed the input register and
// been loaded into the buffer. A plain sample yields 2 or 3 bytes, one per
// cycle while m_tready is high, so the sustained sample rate is set by the
// byte-wide output; a first sample yields 4 to 9 bytes.
// The next sample moves into the buffer in the same cycle the last byte of
// the current one is taken, so no gap appears on the output.
// When the receiver stalls, the buffer holds and the input register fills,
// then s_tready drops. Reset empties both stages, drops pending bits and
// sets the nominal length to 4096.
// ----------------------------------------------------------------------------
module alac_uncompressed_frame_packer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [alacpk_pkg::FRAMES_W-1:0] cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // sample[15:0], frame_frames[28:16]
  input  logic                            s_tuser,   // first
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // out_byte[7:0]
  output logic                            m_tlast
);
  import alacpk_pkg::*;

  logic [FRAMES_W-1:0] nominal;

  logic                a_valid;
  logic [SAMPLE_W-1:0] a_sample;
  logic [FRAMES_W-1:0] a_frames;
  logic                a_first;
  logic                a_last;
  logic                a_load;

  logic [6:0]          carry_bits;
  logic [2:0]          carry_count;

  logic                b_valid;
  logic [BUF_W-1:0]    b_buf;
  logic [3:0]          b_cnt;
  logic                b_last;

  pack_t               packed_item;

  alacpk_compose u_compose (
    .sample       (a_sample),
    .first        (a_first),
    .last         (a_last),
    .frame_frames (a_frames),
    .nominal      (nominal),
    .carry_bits   (carry_bits),
    .carry_count  (carry_count),
    .result       (packed_item)
  );

  assign a_load   = a_valid && (!b_valid || (m_tready && (b_cnt == 4'd1)));
  assign s_tready = !a_valid || a_load;

  assign m_tvalid = b_valid;
  assign m_tdata  = b_buf[BUF_W-1 -: 8];
  assign m_tlast  = b_last && (b_cnt == 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal <= FRAMES_W'(NOMINAL_RESET);
    end else if (cfg_we) begin
      nominal <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      a_valid <= 1'b1;
    end else if (a_load) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_sample <= s_tdata[SAMPLE_W-1:0];
      a_frames <= s_tdata[SAMPLE_W +: FRAMES_W];
      a_first  <= s_tuser;
      a_last   <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_bits  <= 7'd0;
      carry_count <= 3'd0;
    end else if (a_load) begin
      carry_bits  <= packed_item.carry_bits;
      carry_count <= packed_item.carry_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_cnt   <= 4'd0;
    end else if (a_load) begin
      b_valid <= 1'b1;
      b_cnt   <= packed_item.nbytes;
    end else if (b_valid && m_tready) begin
      b_valid <= b_cnt != 4'd1;
      b_cnt   <= b_cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      b_buf  <= packed_item.bits;
      b_last <= a_last;
    end else if (b_valid && m_tready) begin
      b_buf  <= b_buf << 8;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_cnt != 4'd0) && (b_cnt <= 4'd9))
    else $error("byte count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && a_valid) |-> a_load)
    else $error("input register overwritten");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (a_load && a_last) |=> (carry_count == 3'd0) && (carry_bits == 7'd0))
    else $error("pending bits left after frame end");

  a_min_bytes: assert property (@(posedge clk) disable iff (rst)
    a_load |-> (packed_item.nbytes >= 4'd2))
    else $error("sample produced too few bytes");
`endif

endmodule
